// ===== hdl/pip_pkg.sv =====
// shared types and constants of the planar intra predictor
package pip_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int LANE_SLOTS = 8;
   localparam int SUM_W      = 14;

   // function codes of an input beat
   localparam logic [2:0] FUNC_LOAD_TOP   = 3'd0;
   localparam logic [2:0] FUNC_LOAD_LEFT  = 3'd1;
   localparam logic [2:0] FUNC_LOAD_TR    = 3'd2;
   localparam logic [2:0] FUNC_LOAD_BL    = 3'd3;
   localparam logic [2:0] FUNC_PREDICT    = 3'd4;

   // register indexes
   localparam logic CSR_LOG2_WIDTH  = 1'b0;
   localparam logic CSR_LOG2_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0] func;
      logic [5:0] index;
      logic [7:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] pred_sample_0;
      logic [7:0] pred_sample_1;
      logic [7:0] pred_sample_2;
      logic [7:0] pred_sample_3;
      logic [7:0] pred_sample_4;
      logic [7:0] pred_sample_5;
      logic [7:0] pred_sample_6;
      logic [7:0] pred_sample_7;
      logic [5:0] out_row;
      logic [2:0] col_group;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic       load_top;
      logic       load_left;
      logic       load_tr;
      logic       load_bl;
      logic       capture;
      logic       read_left;
      logic       setup;
      logic       issue;
      logic [2:0] group;
      logic       last;
   } pip_cmd_type;

   typedef struct packed {
      logic       row_ok;
      logic       s1_valid;
      logic       advance;
      logic [2:0] last_group;
   } pip_status_type;

endpackage

// ===== hdl/planar_intra_predictor_top.sv =====
// planar intra predictor: top level
// load beats are written on acceptance; a predict beat takes the controller through
// left read, setup and run, which issues G = ceil(width / LANES) groups from the top
// reference row memory, one per cycle while the output advances; each group then
// passes row read, partial sum and output registers; out one per cycle with rsp_ready
// reset: synchronous, clears control state and sets both size registers to 2;
// reference samples are undefined until loaded
module planar_intra_predictor_top #(
   parameter int MAX_SIDE = 64,
   parameter int LANES    = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pip_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pip_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [2:0]               csr_wdata
);
   import pip_pkg::*;

   pip_cmd_type    cmd;
   pip_status_type status;

   pip_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .status      (status),
      .cmd         (cmd)
   );

   pip_datapath #(
      .MAX_SIDE (MAX_SIDE),
      .LANES    (LANES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/pip_ctrl.sv =====
// controller state machine of the planar intra predictor
module pip_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pip_pkg::req_payload_type req_payload,
   input  pip_pkg::pip_status_type  status,
   output pip_pkg::pip_cmd_type     cmd
);
   import pip_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LREAD,
      ST_SETUP,
      ST_RUN
   } state_type;

   state_type  state_ff;
   logic [2:0] group_ff;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd           = '0;
      cmd.load_top  = accept && (req_payload.func == FUNC_LOAD_TOP);
      cmd.load_left = accept && (req_payload.func == FUNC_LOAD_LEFT);
      cmd.load_tr   = accept && (req_payload.func == FUNC_LOAD_TR);
      cmd.load_bl   = accept && (req_payload.func == FUNC_LOAD_BL);
      cmd.capture   = accept && (req_payload.func == FUNC_PREDICT);
      cmd.read_left = (state_ff == ST_LREAD);
      // row constants may change only once no group still needs them
      cmd.setup     = (state_ff == ST_SETUP) && !status.s1_valid;
      cmd.issue     = (state_ff == ST_RUN) && status.advance;
      cmd.group     = group_ff;
      cmd.last      = (group_ff == status.last_group);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         group_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_payload.func == FUNC_PREDICT) && status.row_ok) begin
                  state_ff <= ST_LREAD;
               end
            end
            ST_LREAD: begin
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               if (cmd.setup) begin
                  group_ff <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (cmd.issue) begin
                  if (cmd.last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     group_ff <= group_ff + 3'd1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/pip_datapath.sv =====
// reference stores, row setup and lane pipeline of the planar intra predictor
module pip_datapath #(
   parameter int MAX_SIDE = 64,
   parameter int LANES    = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pip_pkg::req_payload_type  req_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [2:0]                csr_wdata,
   input  pip_pkg::pip_cmd_type      cmd,
   output pip_pkg::pip_status_type   status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pip_pkg::rsp_payload_type  rsp_payload
);
   import pip_pkg::*;

   localparam int SIDE     = (MAX_SIDE < 8 * LANES) ? MAX_SIDE : 8 * LANES;
   localparam int LG_MAX   = (SIDE >= 64) ? 6 : (SIDE >= 32) ? 5 : (SIDE >= 16) ? 4 :
                             (SIDE >= 8) ? 3 : 2;
   localparam int TOP_ROWS = (MAX_SIDE + LANES - 1) / LANES;
   localparam int ROW_AW   = (TOP_ROWS > 1) ? $clog2(TOP_ROWS) : 1;
   localparam int LEFT_AW  = $clog2(MAX_SIDE);
   localparam int LANE_W   = $clog2(LANES);
   localparam logic [2:0] LAST_G2 = 3'((4 + LANES - 1) / LANES - 1);
   localparam logic [2:0] LAST_G3 = 3'((8 + LANES - 1) / LANES - 1);
   localparam logic [2:0] LAST_G4 = 3'((16 + LANES - 1) / LANES - 1);
   localparam logic [2:0] LAST_G5 = 3'((32 + LANES - 1) / LANES - 1);
   localparam logic [2:0] LAST_G6 = 3'((64 + LANES - 1) / LANES - 1);

   // reference stores
   logic [LANES*SAMPLE_W-1:0] top_mem [TOP_ROWS];
   logic [SAMPLE_W-1:0]       left_mem [MAX_SIDE];
   logic [SAMPLE_W-1:0]       tr_ff;
   logic [SAMPLE_W-1:0]       bl_ff;

   logic [2:0] log2_width_ff;
   logic [2:0] log2_height_ff;
   logic [2:0] lw;
   logic [2:0] lh;
   logic [3:0] lwh;
   logic [6:0] w7;
   logic [6:0] h7;

   logic [5:0]          row_y_ff;
   logic [SAMPLE_W-1:0] left_rd_ff;

   // row constants
   logic [5:0]          a_ff;
   logic [SUM_W-1:0]    b_ff;
   logic [SUM_W-1:0]    hc_ff;
   logic signed [8:0]   dlt_ff;
   logic [14:0]         b_in;
   logic [14:0]         hc_in;

   // stage 1: top row read
   logic                      s1_valid_ff;
   logic [LANES*SAMPLE_W-1:0] top_row_ff;
   logic [2:0]                s1_group_ff;
   logic                      s1_last_ff;
   logic [5:0]                s1_row_ff;

   // stage 2: per-lane partial sums
   logic                 s2_valid_ff;
   logic [SUM_W-1:0]     vsum_ff [LANES];
   logic [SUM_W-1:0]     hsum_ff [LANES];
   logic                 inr_ff [LANES];
   logic [SUM_W-1:0]     vsum_in [LANES];
   logic [SUM_W-1:0]     hsum_in [LANES];
   logic                 inr_in [LANES];
   logic [2:0]           s2_group_ff;
   logic                 s2_last_ff;
   logic [5:0]           s2_row_ff;

   // output register
   logic                out_valid_ff;
   logic [SAMPLE_W-1:0] out_lane_ff [LANE_SLOTS];
   logic [SAMPLE_W-1:0] out_lane_in [LANE_SLOTS];
   logic [2:0]          out_group_ff;
   logic                out_last_ff;
   logic [5:0]          out_row_ff;

   logic               advance;
   logic [ROW_AW-1:0]  wr_row;
   logic [LANE_W-1:0]  wr_lane;
   logic [6:0]         wr_base;
   logic [6:0]         wr_off;
   logic [2:0]         last_group;

   always_comb begin
      priority if (log2_width_ff < 3'd2) begin
         lw = 3'd2;
      end else if (log2_width_ff > 3'(LG_MAX)) begin
         lw = 3'(LG_MAX);
      end else begin
         lw = log2_width_ff;
      end
      priority if (log2_height_ff < 3'd2) begin
         lh = 3'd2;
      end else if (log2_height_ff > 3'(LG_MAX)) begin
         lh = 3'(LG_MAX);
      end else begin
         lh = log2_height_ff;
      end
   end

   assign w7  = 7'd1 << lw;
   assign h7  = 7'd1 << lh;
   // log2 of the block area, up to 12
   assign lwh = {1'b0, lw} + {1'b0, lh};

   always_comb begin
      unique case (lw)
         3'd2:    last_group = LAST_G2;
         3'd3:    last_group = LAST_G3;
         3'd4:    last_group = LAST_G4;
         3'd5:    last_group = LAST_G5;
         3'd6:    last_group = LAST_G6;
         default: last_group = LAST_G2;
      endcase
   end

   assign advance = !out_valid_ff || rsp_ready;

   always_comb begin
      status            = '0;
      status.row_ok     = ({1'b0, req_payload.index} < h7);
      status.s1_valid   = s1_valid_ff;
      status.advance    = advance;
      status.last_group = last_group;
   end

   // top load position: row of lanes and lane inside it
   always_comb begin
      wr_row  = '0;
      wr_base = '0;
      for (int r = 1; r < TOP_ROWS; r++) begin
         if ({1'b0, req_payload.index} >= 7'(r * LANES)) begin
            wr_row  = ROW_AW'(r);
            wr_base = 7'(r * LANES);
         end
      end
      wr_off  = {1'b0, req_payload.index} - wr_base;
      wr_lane = wr_off[LANE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_top && ({1'b0, req_payload.index} < 7'(MAX_SIDE))) begin
         top_mem[wr_row][wr_lane*SAMPLE_W +: SAMPLE_W] <= req_payload.sample;
      end
      if (cmd.issue && advance) begin
         top_row_ff <= top_mem[ROW_AW'(cmd.group)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_left && ({1'b0, req_payload.index} < 7'(MAX_SIDE))) begin
         left_mem[req_payload.index[LEFT_AW-1:0]] <= req_payload.sample;
      end
      if (cmd.read_left) begin
         left_rd_ff <= left_mem[row_y_ff[LEFT_AW-1:0]];
      end
   end

   assign b_in  = 15'({1'b0, row_y_ff} + 7'd1) * 15'(bl_ff);
   assign hc_in = 15'(w7 - 7'd1) * 15'(left_rd_ff) + 15'(tr_ff);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [8:0]         xg;
         logic [6:0]         x7;
         logic [SUM_W-1:0]   vp;
         logic signed [15:0] hs;
         xg = 9'(int'(s1_group_ff) * LANES + l);
         x7 = xg[6:0];
         vp = SUM_W'(a_ff) * SUM_W'(top_row_ff[l*SAMPLE_W +: SAMPLE_W]);
         vsum_in[l] = vp + b_ff;
         hs = $signed({2'b00, hc_ff}) + $signed({9'd0, x7}) * 16'(dlt_ff);
         hsum_in[l] = hs[SUM_W-1:0];
         inr_in[l]  = (x7 < w7);
      end
   end

   always_comb begin
      for (int l = 0; l < LANE_SLOTS; l++) begin
         out_lane_in[l] = '0;
      end
      for (int l = 0; l < LANES; l++) begin
         logic [20:0] total;
         logic [20:0] p;
         total = (21'(vsum_ff[l]) << lw) + (21'(hsum_ff[l]) << lh) + (21'd1 << lwh);
         p     = total >> (lwh + 4'd1);
         if (!inr_ff[l]) begin
            out_lane_in[l] = '0;
         end else if (p > 21'd255) begin
            out_lane_in[l] = 8'd255;
         end else begin
            out_lane_in[l] = p[7:0];
         end
      end
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_width_ff  <= 3'd2;
         log2_height_ff <= 3'd2;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LOG2_WIDTH:  log2_width_ff  <= csr_wdata;
               CSR_LOG2_HEIGHT: log2_height_ff <= csr_wdata;
               default:         log2_width_ff  <= log2_width_ff;
            endcase
         end
         if (advance) begin
            s1_valid_ff  <= cmd.issue;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_tr) begin
         tr_ff <= req_payload.sample;
      end
      if (cmd.load_bl) begin
         bl_ff <= req_payload.sample;
      end
      if (cmd.capture) begin
         row_y_ff <= req_payload.index;
      end
      if (cmd.setup) begin
         a_ff   <= 6'(h7 - 7'd1 - {1'b0, row_y_ff});
         b_ff   <= b_in[SUM_W-1:0];
         hc_ff  <= hc_in[SUM_W-1:0];
         dlt_ff <= $signed({1'b0, tr_ff}) - $signed({1'b0, left_rd_ff});
      end
      if (advance) begin
         s1_group_ff  <= cmd.group;
         s1_last_ff   <= cmd.last;
         s1_row_ff    <= row_y_ff;
         s2_group_ff  <= s1_group_ff;
         s2_last_ff   <= s1_last_ff;
         s2_row_ff    <= s1_row_ff;
         out_group_ff <= s2_group_ff;
         out_last_ff  <= s2_last_ff;
         out_row_ff   <= s2_row_ff;
         for (int l = 0; l < LANES; l++) begin
            vsum_ff[l] <= vsum_in[l];
            hsum_ff[l] <= hsum_in[l];
            inr_ff[l]  <= inr_in[l];
         end
         for (int l = 0; l < LANE_SLOTS; l++) begin
            out_lane_ff[l] <= out_lane_in[l];
         end
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      rsp_payload               = '0;
      rsp_payload.pred_sample_0 = out_lane_ff[0];
      rsp_payload.pred_sample_1 = out_lane_ff[1];
      rsp_payload.pred_sample_2 = out_lane_ff[2];
      rsp_payload.pred_sample_3 = out_lane_ff[3];
      rsp_payload.pred_sample_4 = out_lane_ff[4];
      rsp_payload.pred_sample_5 = out_lane_ff[5];
      rsp_payload.pred_sample_6 = out_lane_ff[6];
      rsp_payload.pred_sample_7 = out_lane_ff[7];
      rsp_payload.out_row       = out_row_ff;
      rsp_payload.col_group     = out_group_ff;
      rsp_payload.last          = out_last_ff;
   end

endmodule

// ===== tb/planar_intra_predictor_top_tb.sv =====
// self-checking testbench of the planar intra predictor top level
`timescale 1ns / 1ps

module planar_intra_predictor_top_tb;
   import pip_pkg::*;

   localparam int REF_DEPTH  = 64;
   localparam int LANE_COUNT = 8;
   localparam int LG_MAX     = 6;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 18;
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   // tracks reference samples and block size, predicts the result beats of each row
   class planar_row_tracker;
      logic [7:0]      top_ref [REF_DEPTH];
      logic [7:0]      left_ref [REF_DEPTH];
      logic [7:0]      tr_ref;
      logic [7:0]      bl_ref;
      logic [2:0]      lg_width;
      logic [2:0]      lg_height;
      rsp_payload_type expected_groups[$];
      int              errors;

      function new();
         lg_width  = 3'd2;
         lg_height = 3'd2;
         errors    = 0;
      endfunction

      function int clamp_log2(logic [2:0] v);
         if (v < 3'd2)
            return 2;
         if (int'(v) > LG_MAX)
            return LG_MAX;
         return int'(v);
      endfunction

      function void write_size(logic idx, logic [2:0] value);
         if (idx == CSR_LOG2_WIDTH)
            lg_width = value;
         else
            lg_height = value;
      endfunction

      function logic [7:0] planar_value(int x, int y, int lw, int lh);
         int w, h, vert, horz, p;
         w = 1 << lw;
         h = 1 << lh;
         vert = ((h - 1 - y) * int'(top_ref[x]) + (y + 1) * int'(bl_ref)) << lw;
         horz = ((w - 1 - x) * int'(left_ref[y]) + (x + 1) * int'(tr_ref)) << lh;
         p = (vert + horz + w * h) >> (lw + lh + 1);
         if (p > 255)
            p = 255;
         return p[7:0];
      endfunction

      function void queue_row(int y);
         int lw, lh, w, h, groups, x;
         logic [63:0] lanes;
         rsp_payload_type want;
         lw = clamp_log2(lg_width);
         lh = clamp_log2(lg_height);
         w = 1 << lw;
         h = 1 << lh;
         if (y >= h)
            return;
         groups = (w + LANE_COUNT - 1) / LANE_COUNT;
         for (int g = 0; g < groups; g++) begin
            for (int lane = 0; lane < 8; lane++) begin
               x = g * LANE_COUNT + lane;
               lanes[63 - 8 * lane -: 8] = (x < w) ? planar_value(x, y, lw, lh) : 8'd0;
            end
            want = {lanes, 6'(y), 3'(g), 1'(g == groups - 1)};
            expected_groups.push_back(want);
         end
      endfunction

      function void note_request(req_payload_type beat);
         unique case (beat.func)
            FUNC_LOAD_TOP: begin
               top_ref[beat.index] = beat.sample;
            end
            FUNC_LOAD_LEFT: begin
               left_ref[beat.index] = beat.sample;
            end
            FUNC_LOAD_TR: begin
               tr_ref = beat.sample;
            end
            FUNC_LOAD_BL: begin
               bl_ref = beat.sample;
            end
            FUNC_PREDICT: begin
               queue_row(int'(beat.index));
            end
            default: ;
         endcase
      endfunction

      function void check_group(rsp_payload_type got);
         rsp_payload_type want;
         logic [63:0] want_lanes, got_lanes;
         if (expected_groups.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing pending, got %h", $time, got);
            return;
         end
         want = expected_groups.pop_front();
         want_lanes = {want.pred_sample_0, want.pred_sample_1, want.pred_sample_2,
                       want.pred_sample_3, want.pred_sample_4, want.pred_sample_5,
                       want.pred_sample_6, want.pred_sample_7};
         got_lanes = {got.pred_sample_0, got.pred_sample_1, got.pred_sample_2,
                      got.pred_sample_3, got.pred_sample_4, got.pred_sample_5,
                      got.pred_sample_6, got.pred_sample_7};
         for (int lane = 0; lane < 8; lane++) begin
            if (got_lanes[63 - 8 * lane -: 8] !== want_lanes[63 - 8 * lane -: 8]) begin
               errors++;
               $display("%0t: row %0d group %0d pred_sample_%0d expected %0d got %0d", $time,
                        want.out_row, want.col_group, lane, want_lanes[63 - 8 * lane -: 8],
                        got_lanes[63 - 8 * lane -: 8]);
            end
         end
         if (got.out_row !== want.out_row) begin
            errors++;
            $display("%0t: out_row expected %0d got %0d", $time, want.out_row, got.out_row);
         end
         if (got.col_group !== want.col_group) begin
            errors++;
            $display("%0t: col_group expected %0d got %0d", $time, want.col_group,
                     got.col_group);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_index   = 1'b0;
   logic [2:0]      csr_wdata   = 3'd0;

   planar_row_tracker book = new();
   int burst_left    = 0;
   int rsp_hold_left = 0;
   int cycle_count   = 0;
   logic [2:0] load_funcs [4] = '{FUNC_LOAD_TOP, FUNC_LOAD_LEFT, FUNC_LOAD_TR, FUNC_LOAD_BL};

   planar_intra_predictor_top #(
      .MAX_SIDE(REF_DEPTH),
      .LANES(LANE_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: picks one of four stall patterns at random, plus a long hold-off on request
   initial begin : rsp_side
      int mode, mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            book.check_group(rsp_payload);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            unique case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (mode_left % 8) < 5;
            endcase
         end
      end
   end

   task automatic offer(input logic [2:0] func, input logic [5:0] index,
                        input logic [7:0] sample);
      req_payload_type beat;
      int gap;
      beat.func = func;
      beat.index = index;
      beat.sample = sample;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_payload <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      book.note_request(beat);
   endtask

   // size registers change only once every pending row has come out
   task automatic write_size(input logic idx, input logic [2:0] value);
      req_valid <= 1'b0;
      while (book.expected_groups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.write_size(idx, value);
   endtask

   task automatic run_phase(input logic [2:0] lw_raw, input logic [2:0] lh_raw,
                            input int hold);
      int done_items, h, pick;
      logic [2:0] func;
      logic [5:0] index;
      logic [7:0] sample;
      write_size(CSR_LOG2_WIDTH, lw_raw);
      write_size(CSR_LOG2_HEIGHT, lh_raw);
      h = 1 << book.clamp_log2(lh_raw);
      rsp_hold_left = hold;
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         index = 6'($urandom);
         if ($urandom_range(0, 7) == 0)
            sample = $urandom_range(0, 1) ? 8'hff : 8'h00;
         else
            sample = 8'($urandom);
         if (pick < 55) begin
            func = FUNC_PREDICT;
            // mostly rows inside the block, some past its bottom edge
            if (pick < 48 || h == REF_DEPTH)
               index = 6'($urandom_range(0, h - 1));
            else
               index = 6'($urandom_range(h, REF_DEPTH - 1));
         end else if (pick < 94) begin
            func = load_funcs[$urandom_range(0, 3)];
         end else begin
            func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
         end
         offer(func, index, sample);
         if (func <= FUNC_LOAD_BL || (func == FUNC_PREDICT && int'(index) < h))
            done_items++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every reference entry is written before any row is predicted
      for (int i = 0; i < REF_DEPTH; i++) begin
         offer(FUNC_LOAD_TOP, 6'(i), 8'($urandom));
         offer(FUNC_LOAD_LEFT, 6'(i), 8'($urandom));
      end
      offer(FUNC_LOAD_TR, 6'($urandom), 8'($urandom));
      offer(FUNC_LOAD_BL, 6'($urandom), 8'($urandom));

      // directed part at the reset size of 4x4
      offer(FUNC_LOAD_TOP, 6'd0, 8'hff);
      offer(FUNC_LOAD_TOP, 6'd63, 8'h00);
      offer(FUNC_LOAD_LEFT, 6'd0, 8'hff);
      offer(FUNC_LOAD_LEFT, 6'd63, 8'h00);
      offer(FUNC_LOAD_TR, 6'd63, 8'hff);
      offer(FUNC_LOAD_BL, 6'd0, 8'h00);
      offer(FUNC_PREDICT, 6'd0, 8'hff);
      offer(FUNC_PREDICT, 6'd3, 8'h00);
      offer(FUNC_PREDICT, 6'd63, 8'h5a);
      offer(FUNC_PREDICT, 6'd4, 8'ha5);
      offer(FUNC_UNUSED_LO, 6'd0, 8'h00);
      offer(FUNC_UNUSED_LO + 3'd1, 6'd63, 8'hff);
      offer(FUNC_UNUSED_HI, 6'd21, 8'h3c);
      offer(FUNC_LOAD_TOP, 6'd1, 8'h00);
      offer(FUNC_LOAD_TOP, 6'd2, 8'hff);
      offer(FUNC_LOAD_TOP, 6'd3, 8'hff);
      offer(FUNC_LOAD_LEFT, 6'd1, 8'hff);
      offer(FUNC_LOAD_LEFT, 6'd3, 8'h00);
      offer(FUNC_LOAD_TR, 6'd0, 8'h00);
      offer(FUNC_LOAD_BL, 6'd63, 8'hff);
      offer(FUNC_PREDICT, 6'd1, 8'h00);
      offer(FUNC_PREDICT, 6'd2, 8'hff);
      offer(FUNC_PREDICT, 6'd3, 8'hff);

      // size settings, saturating ones included; long receiver hold-off at 64x64
      run_phase(3'd0, 3'd1, 0);
      run_phase(3'd7, 3'd7, 400);
      run_phase(3'd6, 3'd2, 0);
      run_phase(3'd2, 3'd6, 0);
      run_phase(3'd3, 3'd5, 0);
      run_phase(3'd5, 3'd3, 0);
      run_phase(3'd4, 3'd4, 0);
      run_phase(3'($urandom), 3'($urandom), 0);

      req_valid <= 1'b0;
      while (book.expected_groups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
